@@ rtl/ckc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the RGB color key classifier.
package ckc_pkg;

  localparam int LEVEL_W    = 8;
  localparam int GAIN_W     = 16;
  localparam int THR_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int NODE_COUNT = 16;
  localparam int NODE_W     = 4;
  localparam int NODE_OFS   = (255 + NODE_COUNT) / (2 * NODE_COUNT);

  localparam int SQ_W       = 16;   // one squared channel difference, max 255^2
  localparam int SUM_W      = 18;   // sum of three squares
  localparam int LHS_W      = 34;   // 65025 * sum, and trial^2 * sref
  localparam int ROOT_W     = 8;    // bits of the square root search

  localparam int FRONT_STAGES = 5;
  localparam int PIPE_STAGES  = FRONT_STAGES + 2 * ROOT_W;

  localparam logic [SQ_W-1:0]    FULL_SCALE_SQ = 16'd65025;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 8'd255;
  localparam logic [LEVEL_W-1:0] DIST_TOP      = 8'd254;
  localparam int RAMP_BASE = 100;
  localparam int RAMP_SPAN = 50;
  localparam int RAMP_W    = 6;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
  localparam logic [THR_W-1:0]  THR_RESET  = 9'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEVEL    = 3'd0,
    REG_GAIN_Q8      = 3'd1,
    REG_REF_RED      = 3'd2,
    REG_REF_GREEN    = 3'd3,
    REG_REF_BLUE     = 3'd4,
    REG_THRESHOLD_Q8 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] min_level;
    logic [GAIN_W-1:0]  gain_q8;
    logic [LEVEL_W-1:0] ref_red;
    logic [LEVEL_W-1:0] ref_green;
    logic [LEVEL_W-1:0] ref_blue;
    logic [THR_W-1:0]   threshold_q8;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] distance_level;
    logic [LEVEL_W-1:0] mask_level;
  } res_t;

endpackage

@@ rtl/ckc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixels in and classification results out.
interface ckc_pix_if import ckc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface

interface ckc_res_if import ckc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] distance_level;
  logic [LEVEL_W-1:0] mask_level;

  modport source (output valid, distance_level, mask_level, input ready);
  modport sink   (input valid, distance_level, mask_level, output ready);
endinterface

@@ rtl/ckc_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual port RAM with one write port and a registered read port.
module ckc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ckc_front.sv @@
`timescale 1ns / 1ps
// Pixel normalization, node quantization and squared distance front pipeline.
module ckc_front import ckc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  pix_t             in_pix,
  output logic             out_valid,
  output logic [LHS_W-1:0] out_lhs,
  output logic [SUM_W-1:0] sref
);

  localparam int PROD_W = GAIN_W + LEVEL_W + 2;

  logic [LEVEL_W-1:0]       lvl [3];
  logic [LEVEL_W-1:0]       key_lvl [3];
  logic [FRONT_STAGES-1:0]  vld_r;
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [LEVEL_W:0]  diff_r [3];
  logic [SQ_W-1:0]          sq_r [3];
  logic [SUM_W-1:0]         sum_r;
  logic [LHS_W-1:0]         lhs_r;
  logic [SUM_W-1:0]         sref_r;
  logic [SUM_W-1:0]         sum_nxt;
  logic [LHS_W-1:0]         lhs_nxt;
  logic [SUM_W-1:0]         sref_nxt;

  assign lvl[0]     = in_pix.red;
  assign lvl[1]     = in_pix.green;
  assign lvl[2]     = in_pix.blue;
  assign key_lvl[0] = cfg.ref_red;
  assign key_lvl[1] = cfg.ref_green;
  assign key_lvl[2] = cfg.ref_blue;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic signed [LEVEL_W:0]  d_nxt;
    logic signed [PROD_W-1:0] prod_nxt;
    logic signed [PROD_W-1:0] q_ofs;
    logic [LEVEL_W-1:0]       sat;
    logic [NODE_W-1:0]        node;
    logic [LEVEL_W-1:0]       color;
    logic signed [LEVEL_W:0]  diff_nxt;
    logic signed [2*LEVEL_W+1:0] csq;
    logic [SQ_W-1:0]          sq_nxt;

    always_comb begin
      d_nxt    = $signed({1'b0, lvl[ch]}) - $signed({1'b0, cfg.min_level});
      prod_nxt = $signed({1'b0, cfg.gain_q8}) * d_nxt;
    end

    // arithmetic shift floors negative products
    always_comb begin
      q_ofs = (prod_r[ch] >>> 8) + PROD_W'(NODE_OFS);
      if (q_ofs < 0) begin
        sat = '0;
      end else if (q_ofs > $signed({{(PROD_W-LEVEL_W){1'b0}}, LEVEL_MAX})) begin
        sat = LEVEL_MAX;
      end else begin
        sat = q_ofs[LEVEL_W-1:0];
      end
      node     = sat[LEVEL_W-1 -: NODE_W];
      color    = LEVEL_W'(node) * LEVEL_W'(NODE_COUNT - 1);
      diff_nxt = $signed({1'b0, color}) - $signed({1'b0, key_lvl[ch]});
    end

    always_comb begin
      csq    = diff_r[ch] * diff_r[ch];
      sq_nxt = csq[SQ_W-1:0];
    end

    always_ff @(posedge clk) begin
      prod_r[ch] <= prod_nxt;
      diff_r[ch] <= diff_nxt;
      sq_r[ch]   <= sq_nxt;
    end
  end

  always_comb begin
    sum_nxt  = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    lhs_nxt  = LHS_W'(sum_r) * LHS_W'(FULL_SCALE_SQ);
    sref_nxt = SUM_W'(cfg.ref_red)   * SUM_W'(cfg.ref_red)
             + SUM_W'(cfg.ref_green) * SUM_W'(cfg.ref_green)
             + SUM_W'(cfg.ref_blue)  * SUM_W'(cfg.ref_blue);
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    lhs_r  <= lhs_nxt;
    sref_r <= sref_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[FRONT_STAGES-1];
  assign out_lhs   = lhs_r;
  assign sref      = sref_r;

endmodule

@@ rtl/ckc_root.sv @@
`timescale 1ns / 1ps
// Pipelined square root search, similarity byte and threshold mask.
module ckc_root import ckc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [LHS_W-1:0] in_lhs,
  input  logic [SUM_W-1:0] sref,
  input  logic [THR_W-1:0] threshold_q8,
  output logic             out_valid,
  output res_t             out_res
);

  localparam int LAST  = ROOT_W - 1;
  localparam int CMP_W = RAMP_W + 9;

  logic [ROOT_W-1:0] a_vld_r;
  logic [ROOT_W-1:0] b_vld_r;
  logic [ROOT_W-1:0] a_m_r   [ROOT_W];
  logic [SQ_W-1:0]   a_msq_r [ROOT_W];
  logic [SQ_W-1:0]   a_tsq_r [ROOT_W];
  logic [LHS_W-1:0]  a_prod_r[ROOT_W];
  logic [LHS_W-1:0]  a_lhs_r [ROOT_W];
  logic [ROOT_W-1:0] b_m_r   [ROOT_W];
  logic [SQ_W-1:0]   b_msq_r [ROOT_W];
  logic [LHS_W-1:0]  b_lhs_r [ROOT_W];

  // Each bit takes two stages: trial square times sref, then compare.
  // b_m_r ends as the largest m with m*m*sref < lhs.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
    localparam int K = ROOT_W - 1 - i;
    logic [ROOT_W-1:0] m_in;
    logic [SQ_W-1:0]   msq_in;
    logic [LHS_W-1:0]  lhs_in;
    logic              vld_in;
    logic [SQ_W-1:0]   tsq_nxt;
    logic [LHS_W-1:0]  prod_nxt;
    logic              hit;
    logic [ROOT_W-1:0] m_nxt;
    logic [SQ_W-1:0]   msq_nxt;

    if (i == 0) begin : g_first
      assign m_in   = '0;
      assign msq_in = '0;
      assign lhs_in = in_lhs;
      assign vld_in = in_valid;
    end else begin : g_next
      assign m_in   = b_m_r[i-1];
      assign msq_in = b_msq_r[i-1];
      assign lhs_in = b_lhs_r[i-1];
      assign vld_in = b_vld_r[i-1];
    end

    // (m + 2^K)^2 = m^2 + m*2^(K+1) + 2^(2K)
    always_comb begin
      tsq_nxt  = msq_in + (SQ_W'(m_in) << (K + 1)) + (SQ_W'(1) << (2 * K));
      prod_nxt = LHS_W'(tsq_nxt) * LHS_W'(sref);
    end

    always_comb begin
      hit     = a_prod_r[i] < a_lhs_r[i];
      m_nxt   = hit ? (a_m_r[i] | (ROOT_W'(1) << K)) : a_m_r[i];
      msq_nxt = hit ? a_tsq_r[i] : a_msq_r[i];
    end

    always_ff @(posedge clk) begin
      a_m_r[i]    <= m_in;
      a_msq_r[i]  <= msq_in;
      a_tsq_r[i]  <= tsq_nxt;
      a_prod_r[i] <= prod_nxt;
      a_lhs_r[i]  <= lhs_in;
      b_m_r[i]    <= m_nxt;
      b_msq_r[i]  <= msq_nxt;
      b_lhs_r[i]  <= a_lhs_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r[i] <= 1'b0;
        b_vld_r[i] <= 1'b0;
      end else begin
        a_vld_r[i] <= vld_in;
        b_vld_r[i] <= a_vld_r[i];
      end
    end
  end

  logic [LEVEL_W-1:0] m_fin;
  logic [LEVEL_W-1:0] simil;
  logic [LEVEL_W-1:0] over;
  logic [RAMP_W-1:0]  ramp;
  logic [CMP_W-1:0]   ramp_sc;
  logic [CMP_W-1:0]   thr_sc;

  // least m is one above the search result; none found in range gives zero
  always_comb begin
    m_fin = b_m_r[LAST];
    if (sref == '0) begin
      simil = '0;
    end else if (b_lhs_r[LAST] == '0) begin
      simil = LEVEL_MAX;
    end else if (m_fin == LEVEL_MAX) begin
      simil = '0;
    end else begin
      simil = DIST_TOP - m_fin;
    end
  end

  always_comb begin
    if (simil > LEVEL_W'(RAMP_BASE)) begin
      over = simil - LEVEL_W'(RAMP_BASE);
    end else begin
      over = '0;
    end
    if (over > LEVEL_W'(RAMP_SPAN)) begin
      ramp = RAMP_W'(RAMP_SPAN);
    end else begin
      ramp = over[RAMP_W-1:0];
    end
    ramp_sc = {1'b0, ramp, 8'h00};
    thr_sc  = CMP_W'(RAMP_SPAN) * CMP_W'(threshold_q8);
  end

  assign out_valid              = b_vld_r[LAST];
  assign out_res.distance_level = simil;
  assign out_res.mask_level     = (ramp_sc >= thr_sc) ? LEVEL_MAX : '0;

endmodule

@@ rtl/ckc_fifo.sv @@
`timescale 1ns / 1ps
// RAM-based result queue with credit count and registered output stage.
module ckc_fifo import ckc_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  logic wr_en,
  input  res_t wr_data,
  output logic credit,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = $bits(res_t);

  logic [CW-1:0] occ_r, occ_nxt;          // items in the pipeline plus items in RAM
  logic [CW-1:0] ram_cnt_r, ram_cnt_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          out_vld_r, out_vld_nxt;
  res_t          out_data_r;
  logic [DW-1:0] ram_q;
  logic          rd_adv;
  logic          issue;

  ckc_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr_r),
    .wdata (wr_data),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (ram_q)
  );

  // RAM read data holds while not re-read, so it acts as a stage of its own
  always_comb begin
    rd_adv      = rd_vld_r && (!out_vld_r || out_ready);
    issue       = (ram_cnt_r != '0) && (!rd_vld_r || rd_adv);
    occ_nxt     = occ_r + CW'(accept) - CW'(issue);
    ram_cnt_nxt = ram_cnt_r + CW'(wr_en) - CW'(issue);
    wr_ptr_nxt  = wr_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    rd_ptr_nxt = rd_ptr_r;
    if (issue) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    rd_vld_nxt = issue || (rd_vld_r && !rd_adv);
    if (rd_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      ram_cnt_r <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      occ_r     <= occ_nxt;
      ram_cnt_r <= ram_cnt_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_adv) begin
      out_data_r <= res_t'(ram_q);
    end
  end

  assign credit    = occ_r < CW'(DEPTH);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (ram_cnt_r < CW'(DEPTH)))
    else $error("result written into a full queue");

  a_ram_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_cnt_r <= occ_r)
    else $error("queue holds more results than credits taken");

  a_pipe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(occ_r) - int'(ram_cnt_r)) <= PIPE_STAGES)
    else $error("more transactions in flight than pipeline stages");
`endif

endmodule

@@ rtl/rgb_color_key_classifier.sv @@
`timescale 1ns / 1ps
// Top level of the RGB color key classifier.
//
// in_ch carries one RGB pixel per transaction; out_ch returns one result per
// pixel, in order: an 8-bit similarity to the reference color and a 0/255 mask.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it.
// Throughput: one pixel per clock while in_ch.ready is high. Each pixel runs a
// fixed pipeline of 21 stages (5 for normalization and squared distance, 16 for
// the two-stage-per-bit square root search), then goes through a result queue
// held in a RAM, its read register and an output register.
//
// in_ch.ready is a credit check: it drops once FIFO_DEPTH pixels are in the
// pipeline or waiting in the queue RAM, so a stalled receiver never loses a
// result. A transaction holds its credit until it is read from the queue RAM,
// so full rate needs FIFO_DEPTH of at least 23; the default of 32 sustains it.
//
// Reset (synchronous, active low) empties the pipeline and queue and loads the
// register reset values. No clearing pass is needed.
module rgb_color_key_classifier import ckc_pkg::*; #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ckc_pix_if.sink               in_ch,
  ckc_res_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t             cfg_r, cfg_nxt;
  pix_t             pix;
  logic             accept;
  logic             credit;
  logic             front_vld;
  logic [LHS_W-1:0] front_lhs;
  logic [SUM_W-1:0] sref;
  logic             root_vld;
  res_t             root_res;
  res_t             out_res;
  logic             out_vld;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_LEVEL:    cfg_nxt.min_level    = cfg_wdata[LEVEL_W-1:0];
        REG_GAIN_Q8:      cfg_nxt.gain_q8      = cfg_wdata[GAIN_W-1:0];
        REG_REF_RED:      cfg_nxt.ref_red      = cfg_wdata[LEVEL_W-1:0];
        REG_REF_GREEN:    cfg_nxt.ref_green    = cfg_wdata[LEVEL_W-1:0];
        REG_REF_BLUE:     cfg_nxt.ref_blue     = cfg_wdata[LEVEL_W-1:0];
        REG_THRESHOLD_Q8: cfg_nxt.threshold_q8 = cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_level    <= '0;
      cfg_r.gain_q8      <= GAIN_RESET;
      cfg_r.ref_red      <= '0;
      cfg_r.ref_green    <= '0;
      cfg_r.ref_blue     <= '0;
      cfg_r.threshold_q8 <= THR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ch.ready = credit;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pix.red     = in_ch.red_level;
  assign pix.green   = in_ch.green_level;
  assign pix.blue    = in_ch.blue_level;

  ckc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (accept),
    .in_pix    (pix),
    .out_valid (front_vld),
    .out_lhs   (front_lhs),
    .sref      (sref)
  );

  ckc_root u_root (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (front_vld),
    .in_lhs       (front_lhs),
    .sref         (sref),
    .threshold_q8 (cfg_r.threshold_q8),
    .out_valid    (root_vld),
    .out_res      (root_res)
  );

  ckc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .wr_en     (root_vld),
    .wr_data   (root_res),
    .credit    (credit),
    .out_valid (out_vld),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.valid          = out_vld;
  assign out_ch.distance_level = out_res.distance_level;
  assign out_ch.mask_level     = out_res.mask_level;

endmodule

@@ dv/rgb_color_key_classifier_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the RGB color key classifier: directed and random pixels.
module rgb_color_key_classifier_tb;
  import ckc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_PIXELS = 300;
  localparam int GAP_PERCENT = 11;
  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ckc_pix_if pix_if ();
  ckc_res_if res_if ();

  rgb_color_key_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_if.sink),
    .out_ch    (res_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t model_cfg;
  res_t expected_results[$];
  int   failures;
  int   cycle_count;
  bit   send_gaps;
  bit   recv_stalls;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk)
    res_if.ready <= recv_stalls ? ($urandom_range(99) >= GAP_PERCENT) : 1'b1;

  // Similarity and mask of one pixel under a given register set.
  function automatic res_t classify_pixel(input pix_t px, input cfg_t c);
    int     level[3];
    int     refc[3];
    int     prod;
    int     q;
    int     node_col;
    int     m;
    int     simil;
    int     ramp;
    int     i;
    bit     found;
    longint sum_sq;
    longint ref_sq;
    longint scaled;
    res_t   r;
    level = '{int'(px.red), int'(px.green), int'(px.blue)};
    refc = '{int'(c.ref_red), int'(c.ref_green), int'(c.ref_blue)};
    sum_sq = 0;
    ref_sq = 0;
    for (i = 0; i < 3; i++) begin
      prod = int'(c.gain_q8) * (level[i] - int'(c.min_level));
      q = (prod >>> 8) + NODE_OFS;  // floor for negative products too
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      node_col = (q >> NODE_W) * (NODE_COUNT - 1);
      sum_sq += longint'(node_col - refc[i]) * (node_col - refc[i]);
      ref_sq += longint'(refc[i]) * refc[i];
    end
    simil = 0;
    if (ref_sq != 0) begin
      scaled = 65025 * sum_sq;
      found = 1'b0;
      m = 0;
      while (!found && m <= 255) begin
        if (longint'(m) * m * ref_sq >= scaled) begin
          simil = 255 - m;
          found = 1'b1;
        end
        m++;
      end
    end
    ramp = (simil > 100) ? simil - 100 : 0;
    if (ramp > 50) ramp = 50;
    r.distance_level = simil[7:0];
    r.mask_level = (ramp * 256 >= 50 * int'(c.threshold_q8)) ? 8'd255 : 8'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.distance_level = res_if.distance_level;
      got.mask_level = res_if.mask_level;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: distance_level %0d mask_level %0d",
               got.distance_level, got.mask_level);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (got.distance_level !== want.distance_level) begin
          $error("distance_level: expected %0d, actual %0d",
                 want.distance_level, got.distance_level);
          failures++;
        end
        if (got.mask_level !== want.mask_level) begin
          $error("mask_level: expected %0d, actual %0d", want.mask_level, got.mask_level);
          failures++;
        end
      end
    end
  end

  task automatic send_pixel(input pix_t px);
    @(negedge clk);
    if (send_gaps && $urandom_range(99) < GAP_PERCENT) begin
      pix_if.valid = 1'b0;
      @(negedge clk);
    end
    pix_if.valid = 1'b1;
    pix_if.red_level = px.red;
    pix_if.green_level = px.green;
    pix_if.blue_level = px.blue;
    do @(posedge clk); while (pix_if.ready !== 1'b1);
    expected_results.push_back(classify_pixel(px, model_cfg));
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    pix_t px;
    px.red = r[7:0];
    px.green = g[7:0];
    px.blue = b[7:0];
    send_pixel(px);
  endtask

  // Let the pipeline empty so that registers can be rewritten safely.
  task automatic drain_results();
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MIN_LEVEL:    model_cfg.min_level = data[LEVEL_W-1:0];
      REG_GAIN_Q8:      model_cfg.gain_q8 = data[GAIN_W-1:0];
      REG_REF_RED:      model_cfg.ref_red = data[LEVEL_W-1:0];
      REG_REF_GREEN:    model_cfg.ref_green = data[LEVEL_W-1:0];
      REG_REF_BLUE:     model_cfg.ref_blue = data[LEVEL_W-1:0];
      REG_THRESHOLD_Q8: model_cfg.threshold_q8 = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits are filled with junk; the block must drop them.
  task automatic write_config(input cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    drain_results();
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_MIN_LEVEL, {junk[15:8], c.min_level});
    write_reg(REG_GAIN_Q8, c.gain_q8);
    write_reg(REG_REF_RED, {junk[7:0], c.ref_red});
    write_reg(REG_REF_GREEN, {junk[15:8], c.ref_green});
    write_reg(REG_REF_BLUE, {junk[11:4], c.ref_blue});
    write_reg(REG_THRESHOLD_Q8, {junk[6:0], c.threshold_q8});
  endtask

  function automatic cfg_t make_cfg(input int mn, input int gain, input int r, input int g,
                                    input int b, input int thr);
    cfg_t c;
    c.min_level = mn[7:0];
    c.gain_q8 = gain[15:0];
    c.ref_red = r[7:0];
    c.ref_green = g[7:0];
    c.ref_blue = b[7:0];
    c.threshold_q8 = thr[8:0];
    return c;
  endfunction

  // Input level that lands near a reference level under the current black level and gain.
  function automatic logic [7:0] level_near(input logic [7:0] target);
    int v;
    if (model_cfg.gain_q8 == 0)
      v = $urandom_range(255);
    else
      v = int'(model_cfg.min_level) + (int'(target) * 256) / int'(model_cfg.gain_q8)
          + $urandom_range(24) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic test_reset_values();
    // reference is all zero after reset: similarity 0, mask 0 at default threshold
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    drain_results();
  endtask

  task automatic test_exact_match();
    write_config(make_cfg(0, 256, 120, 45, 225, 128));
    send_rgb(120, 40, 240);  // lands exactly on the reference node colors
    send_rgb(0, 255, 0);
    send_rgb(170, 85, 34);
  endtask

  task automatic test_black_level();
    // pixels below the black level give negative products, floored then clipped
    write_config(make_cfg(200, 65535, 30, 200, 90, 64));
    send_rgb(0, 199, 200);
    send_rgb(201, 255, 1);
    write_config(make_cfg(255, 0, 255, 255, 255, 128));
    send_rgb(0, 128, 255);
  endtask

  task automatic test_zero_reference();
    write_config(make_cfg(0, 256, 0, 0, 0, 0));
    send_rgb(0, 0, 0);
    send_rgb(255, 0, 128);
  endtask

  task automatic test_threshold_extremes();
    write_config(make_cfg(0, 256, 120, 45, 225, 0));   // mask always set
    send_rgb(120, 40, 240);
    send_rgb(0, 0, 0);
    write_config(make_cfg(0, 256, 120, 45, 225, 256));
    send_rgb(120, 40, 240);
    send_rgb(121, 45, 230);
    write_config(make_cfg(0, 256, 120, 45, 225, 300));  // above one: mask never set
    send_rgb(120, 40, 240);
    write_config(make_cfg(0, 256, 120, 45, 225, 511));
    send_rgb(120, 40, 240);
  endtask

  task automatic test_register_decode();
    write_config(make_cfg(0, 256, 60, 150, 15, 100));
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    send_rgb(60, 150, 15);
    send_rgb(85, 170, 255);
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    pix_t px;
    int   phase;
    int   n;
    for (phase = 0; phase < 6; phase++) begin
      c = make_cfg($urandom_range(255), $urandom_range(65535), $urandom_range(255),
                   $urandom_range(255), $urandom_range(255), $urandom_range(511));
      case (phase)
        0: begin
          c.min_level = 0;
          c.gain_q8 = 16'd256;
          c.threshold_q8 = 9'($urandom_range(256));
        end
        1: begin
          c.min_level = 8'($urandom_range(40));
          c.gain_q8 = 16'($urandom_range(200, 400));
          c.threshold_q8 = 9'($urandom_range(256));
        end
        2: c = make_cfg(255, 65535, 255, 255, 255, 256);
        3: begin
          c.gain_q8 = 16'd0;
          c.threshold_q8 = 9'd0;
        end
        4: begin
          c.ref_green = 8'd0;
          c.gain_q8 = 16'($urandom_range(128, 512));
        end
        default: c.threshold_q8 = 9'($urandom_range(257, 511));
      endcase
      write_config(c);
      // one phase runs back to back on both sides
      send_gaps = (phase != 2);
      recv_stalls = (phase != 2);
      for (n = 0; n < PHASE_PIXELS; n++) begin
        if ($urandom_range(99) < 60) begin
          px.red = level_near(model_cfg.ref_red);
          px.green = level_near(model_cfg.ref_green);
          px.blue = level_near(model_cfg.ref_blue);
        end else begin
          px = pix_t'($urandom);
        end
        send_pixel(px);
      end
    end
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    write_config(make_cfg(0, 256, 0, 0, 0, 128));
  endtask

  initial begin
    failures = 0;
    cycle_count = 0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pix_if.valid = 1'b0;
    pix_if.red_level = '0;
    pix_if.green_level = '0;
    pix_if.blue_level = '0;
    res_if.ready = 1'b0;
    model_cfg = make_cfg(0, GAIN_RESET, 0, 0, 0, THR_RESET);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_exact_match();
    test_black_level();
    test_zero_reference();
    test_threshold_extremes();
    test_register_decode();
    test_random_traffic();

    drain_results();
    if (failures == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
